### rtl/stunbr_pkg.sv
// Shared types and constants for the STUN Binding response parser.
// No dependencies; used by stun_binding_response_parser_core.
package stunbr_pkg;

  localparam int unsigned MAX_DATAGRAM = 512;
  localparam int unsigned COUNT_W      = $clog2(MAX_DATAGRAM + 1);

  localparam logic [31:0] COOKIE          = 32'h2112A442;
  localparam logic [15:0] TYPE_BINDING_OK = 16'h0101;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
  localparam logic [15:0] XMA_MIN_LEN     = 16'd8;
  localparam logic [16:0] HEADER_LEN      = 17'd20;

  localparam logic CFG_TXN_UPPER = 1'b0;
  localparam logic CFG_TXN_LOWER = 1'b1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_COOKIE,
    ST_TXN,
    ST_TYPE,
    ST_LENGTH,
    ST_OVERRUN,
    ST_NONE_FOUND
  } status_t;

  typedef enum logic [1:0] {
    WALK_NONE,
    WALK_FOUND,
    WALK_OVERRUN
  } walk_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] mapped_addr;
    logic [15:0] mapped_port;
  } result_req_t;

endpackage

### rtl/stun_binding_response_parser_core.sv
// STUN Binding response parser top level: header check, attribute walk, result register.
// Depends on stunbr_pkg.
//
// Takes one datagram byte per cycle and returns one result request on the final byte:
// status, then the XOR-MAPPED-ADDRESS IPv4 address and port (zero unless status is OK).
// Each byte updates the parse registers in the cycle it is accepted. The result is valid in
// the cycle after the final byte and sits in an output register. byte_stall is raised only
// while a result is held and result_stall is high, so the byte side waits for as long as the
// result side stalls. Otherwise the sustained rate is one byte per cycle. The user writes
// the expected transaction ID through cfg_* while no datagram is in flight; not enforced.
module stun_binding_response_parser_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_stall,
  input  stunbr_pkg::byte_req_t    byte_req,
  output logic                     result_valid,
  input  logic                     result_stall,
  output stunbr_pkg::result_req_t  result_req,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [63:0]              cfg_data
);

  logic [31:0] txn_id_upper;
  logic [63:0] txn_id_lower;

  logic [stunbr_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0] message_type, message_type_next;
  logic [15:0] message_length, message_length_next;
  logic        cookie_fault, cookie_fault_next;
  logic        txn_fault, txn_fault_next;
  logic [16:0] next_attr_start, next_attr_start_next;
  logic [15:0] attr_kind, attr_kind_next;
  logic [15:0] attr_length, attr_length_next;
  logic [7:0]  addr_family, addr_family_next;
  logic [15:0] port_shift, port_shift_next;
  logic [31:0] addr_shift, addr_shift_next;
  stunbr_pkg::walk_t walk_outcome, walk_outcome_next;

  logic                    result_valid_next;
  stunbr_pkg::result_req_t result_req_next;
  logic                    accept;

  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      txn_id_upper <= '0;
      txn_id_lower <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        stunbr_pkg::CFG_TXN_UPPER: txn_id_upper <= cfg_data[31:0];
        stunbr_pkg::CFG_TXN_LOWER: txn_id_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [stunbr_pkg::COUNT_W-1:0] p_count;
    logic [15:0] p_type, p_length, p_kind, p_alen, p_port;
    logic        p_cookie, p_txn;
    logic [16:0] p_nas;
    logic [7:0]  p_family;
    logic [31:0] p_addr;
    stunbr_pkg::walk_t p_walk;
    logic [7:0]  b;
    logic [95:0] txn_id;
    logic [3:0]  txn_lane;
    logic [7:0]  expect_byte;
    logic [16:0] attr_end;
    logic [16:0] pos;
    logic [16:0] rel;
    logic [15:0] len_full;
    logic [16:0] skip_len;
    stunbr_pkg::status_t st;

    p_count  = byte_count;
    p_type   = message_type;
    p_length = message_length;
    p_cookie = cookie_fault;
    p_txn    = txn_fault;
    p_nas    = next_attr_start;
    p_kind   = attr_kind;
    p_alen   = attr_length;
    p_family = addr_family;
    p_port   = port_shift;
    p_addr   = addr_shift;
    p_walk   = walk_outcome;
    b        = byte_req.data_byte;
    txn_id   = {txn_id_upper, txn_id_lower};
    txn_lane = 4'(byte_count - stunbr_pkg::COUNT_W'(8));
    expect_byte = '0;
    attr_end = stunbr_pkg::HEADER_LEN + {1'b0, message_length};
    pos      = 17'(byte_count);
    rel      = pos - next_attr_start;
    len_full = {attr_length[15:8], b};
    skip_len = '0;

    if (accept && (byte_count < stunbr_pkg::COUNT_W'(stunbr_pkg::MAX_DATAGRAM))) begin
      p_count = byte_count + stunbr_pkg::COUNT_W'(1);
      if (byte_count < stunbr_pkg::COUNT_W'(2)) begin
        p_type = {message_type[7:0], b};
      end else if (byte_count < stunbr_pkg::COUNT_W'(4)) begin
        p_length = {message_length[7:0], b};
      end else if (byte_count < stunbr_pkg::COUNT_W'(8)) begin
        expect_byte = stunbr_pkg::COOKIE[8 * (3 - int'(byte_count[1:0])) +: 8];
        if (b != expect_byte) p_cookie = 1'b1;
      end else if (byte_count < stunbr_pkg::COUNT_W'(20)) begin
        expect_byte = txn_id[8 * (11 - int'(txn_lane)) +: 8];
        if (b != expect_byte) p_txn = 1'b1;
      end else if ((walk_outcome == stunbr_pkg::WALK_NONE) && (pos >= next_attr_start) &&
                   (({1'b0, next_attr_start} + 18'd4) <= {1'b0, attr_end})) begin
        case (rel)
          17'd0: p_kind = {b, 8'h00};
          17'd1: p_kind = {attr_kind[15:8], b};
          17'd2: p_alen = {b, 8'h00};
          17'd3: begin
            p_alen   = len_full;
            skip_len = ({1'b0, len_full} + 17'd3) & ~17'd3;
            if (({1'b0, next_attr_start} + 18'd4 + {2'b00, len_full}) > {1'b0, attr_end}) begin
              p_walk = stunbr_pkg::WALK_OVERRUN;
            end else if ((attr_kind != stunbr_pkg::ATTR_XOR_MAPPED) ||
                         (len_full < stunbr_pkg::XMA_MIN_LEN)) begin
              p_nas = next_attr_start + 17'd4 + skip_len;
            end
          end
          17'd5: p_family = b;
          17'd6: p_port = {b, 8'h00};
          17'd7: p_port = {port_shift[15:8], b};
          17'd8, 17'd9, 17'd10: p_addr = {addr_shift[23:0], b};
          17'd11: begin
            p_addr   = {addr_shift[23:0], b};
            skip_len = ({1'b0, attr_length} + 17'd3) & ~17'd3;
            if (addr_family == stunbr_pkg::FAMILY_IPV4) begin
              p_walk = stunbr_pkg::WALK_FOUND;
            end else begin
              p_nas = next_attr_start + 17'd4 + skip_len;
            end
          end
          default: ;
        endcase
      end
    end

    if (p_count < stunbr_pkg::COUNT_W'(20)) begin
      st = stunbr_pkg::ST_SHORT;
    end else if (p_cookie) begin
      st = stunbr_pkg::ST_COOKIE;
    end else if (p_txn) begin
      st = stunbr_pkg::ST_TXN;
    end else if (p_type != stunbr_pkg::TYPE_BINDING_OK) begin
      st = stunbr_pkg::ST_TYPE;
    end else if ((stunbr_pkg::HEADER_LEN + {1'b0, p_length}) > 17'(p_count)) begin
      st = stunbr_pkg::ST_LENGTH;
    end else if (p_walk == stunbr_pkg::WALK_FOUND) begin
      st = stunbr_pkg::ST_OK;
    end else if (p_walk == stunbr_pkg::WALK_OVERRUN) begin
      st = stunbr_pkg::ST_OVERRUN;
    end else begin
      st = stunbr_pkg::ST_NONE_FOUND;
    end

    result_req_next.status      = st;
    result_req_next.mapped_addr = (st == stunbr_pkg::ST_OK) ?
                                  (p_addr ^ stunbr_pkg::COOKIE) : 32'h0;
    result_req_next.mapped_port = (st == stunbr_pkg::ST_OK) ?
                                  (p_port ^ stunbr_pkg::COOKIE[31:16]) : 16'h0;

    result_valid_next = (accept && byte_req.last_byte) || (result_valid && result_stall);

    if (accept && byte_req.last_byte) begin
      byte_count_next      = '0;
      message_type_next    = '0;
      message_length_next  = '0;
      cookie_fault_next    = 1'b0;
      txn_fault_next       = 1'b0;
      next_attr_start_next = stunbr_pkg::HEADER_LEN;
      attr_kind_next       = '0;
      attr_length_next     = '0;
      addr_family_next     = '0;
      port_shift_next      = '0;
      addr_shift_next      = '0;
      walk_outcome_next    = stunbr_pkg::WALK_NONE;
    end else begin
      byte_count_next      = p_count;
      message_type_next    = p_type;
      message_length_next  = p_length;
      cookie_fault_next    = p_cookie;
      txn_fault_next       = p_txn;
      next_attr_start_next = p_nas;
      attr_kind_next       = p_kind;
      attr_length_next     = p_alen;
      addr_family_next     = p_family;
      port_shift_next      = p_port;
      addr_shift_next      = p_addr;
      walk_outcome_next    = p_walk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      message_type    <= '0;
      message_length  <= '0;
      cookie_fault    <= 1'b0;
      txn_fault       <= 1'b0;
      next_attr_start <= stunbr_pkg::HEADER_LEN;
      attr_kind       <= '0;
      attr_length     <= '0;
      addr_family     <= '0;
      port_shift      <= '0;
      addr_shift      <= '0;
      walk_outcome    <= stunbr_pkg::WALK_NONE;
      result_valid    <= 1'b0;
    end else begin
      byte_count      <= byte_count_next;
      message_type    <= message_type_next;
      message_length  <= message_length_next;
      cookie_fault    <= cookie_fault_next;
      txn_fault       <= txn_fault_next;
      next_attr_start <= next_attr_start_next;
      attr_kind       <= attr_kind_next;
      attr_length     <= attr_length_next;
      addr_family     <= addr_family_next;
      port_shift      <= port_shift_next;
      addr_shift      <= addr_shift_next;
      walk_outcome    <= walk_outcome_next;
      result_valid    <= result_valid_next;
    end
  end

  // result payload: loaded on the final byte only
  always_ff @(posedge clk) begin
    if (accept && byte_req.last_byte) begin
      result_req <= result_req_next;
    end
  end

endmodule
